// ----- hdl/hip_frame_deframer_macros.svh -----
// Assertion macros used by the frame deframer checker
`ifndef HIP_FRAME_DEFRAMER_MACROS_SVH
`define HIP_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define HFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define HFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/hfd_pkg.sv -----
// Types and constants of the frame deframer
package hfd_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAC   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ETHER_TYPE = 1'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_HDR_CUT = 2'd1;
	localparam logic [1:0] ST_LEN_ERR = 2'd2;
	localparam logic [1:0] ST_NOT_IP  = 2'd3;

	localparam logic [6:0]  ID_EXTENDED = 7'h7F;
	localparam logic [9:0]  EXT_ID_DATA = 10'h202;
	localparam logic [15:0] LEN_MASK_SHORT = 16'h07FF;
	localparam logic [15:0] LEN_MASK_EXT   = 16'h3FFF;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       transfer_last;
	} hfd_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       frame_end;
		logic [1:0] frame_status;
	} hfd_out_t;

	typedef struct packed {
		logic [47:0] dest_mac;
		logic [15:0] ether_type;
	} hfd_cfg_t;

endpackage

// ----- hdl/hfd_parse.sv -----
// Frame parser: header collection, payload rewrite and error tracking
module hfd_parse
	import hfd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  hfd_in_t  item,
	input  hfd_cfg_t cfg,
	output logic     has_res,
	output hfd_out_t res
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_SKIP    = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic [2:0]  hcount_q, hcount_d;
	logic [47:0] hbytes_q, hbytes_d;
	logic [15:0] flen_q, flen_d;
	logic [15:0] bcount_q, bcount_d;
	logic [1:0]  pend_q, pend_d;

	logic [7:0]  eth_b;
	logic [15:0] bc_inc;
	logic [47:0] hb_new;
	logic [2:0]  hc_new;
	logic [7:0]  id;
	logic        pad, ext, ok;
	logic [2:0]  hlen;
	logic [15:0] len;

	// Ethernet header substitution for the first fourteen payload bytes
	always_comb begin
		eth_b = item.rx_byte;
		if (bcount_q[15:4] == 12'd0) begin
			case (bcount_q[3:0])
				4'd0: eth_b = cfg.dest_mac[47:40];
				4'd1: eth_b = cfg.dest_mac[39:32];
				4'd2: eth_b = cfg.dest_mac[31:24];
				4'd3: eth_b = cfg.dest_mac[23:16];
				4'd4: eth_b = cfg.dest_mac[15:8];
				4'd5: eth_b = cfg.dest_mac[7:0];
				4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: eth_b = 8'd0;
				4'd12: eth_b = cfg.ether_type[15:8];
				4'd13: eth_b = cfg.ether_type[7:0];
				default: eth_b = item.rx_byte;
			endcase
		end
	end

	// Header byte collection
	always_comb begin
		hb_new = (hcount_q == 3'd0) ? 48'd0 : hbytes_q;
		case (hcount_q)
			3'd0: hb_new[47:40] = item.rx_byte;
			3'd1: hb_new[39:32] = item.rx_byte;
			3'd2: hb_new[31:24] = item.rx_byte;
			3'd3: hb_new[23:16] = item.rx_byte;
			3'd4: hb_new[15:8]  = item.rx_byte;
			3'd5: hb_new[7:0]   = item.rx_byte;
			default: ;
		endcase
		hc_new = (hcount_q == 3'd7) ? hcount_q : hcount_q + 3'd1;
		id     = hb_new[31:24];
		pad    = id[7];
		ext    = (id[6:0] == ID_EXTENDED);
		hlen   = (ext ? 3'd6 : 3'd4) + {2'd0, pad};
		len    = hb_new[47:32] & (ext ? LEN_MASK_EXT : LEN_MASK_SHORT);
		if (pad)
			len = len - 16'd1;
		ok     = ext && (hb_new[9:0] == EXT_ID_DATA);
	end

	assign bc_inc = bcount_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		hcount_d = hcount_q;
		hbytes_d = hbytes_q;
		flen_d   = flen_q;
		bcount_d = bcount_q;
		pend_d   = pend_q;
		has_res  = 1'b0;
		res      = '0;
		case (phase_q)
			PH_PAYLOAD: begin
				has_res  = 1'b1;
				bcount_d = bc_inc;
				if (bc_inc == flen_q) begin
					res = '{out_byte: eth_b, out_valid: 1'b1, frame_end: 1'b1,
						frame_status: ST_OK};
				end else if (item.transfer_last) begin
					res = '{out_byte: 8'd0, out_valid: 1'b0, frame_end: 1'b1,
						frame_status: ST_LEN_ERR};
				end else begin
					res = '{out_byte: eth_b, out_valid: 1'b1, frame_end: 1'b0,
						frame_status: ST_OK};
				end
				if (bc_inc == flen_q || item.transfer_last) begin
					phase_d  = PH_HEADER;
					hcount_d = 3'd0;
					bcount_d = 16'd0;
					pend_d   = ST_OK;
				end
			end
			PH_SKIP: begin
				if (bcount_q < flen_q)
					bcount_d = bc_inc;
				if (item.transfer_last) begin
					has_res = 1'b1;
					res = '{out_byte: 8'd0, out_valid: 1'b0, frame_end: 1'b1,
						frame_status: (bcount_d < flen_q) ? ST_LEN_ERR : pend_q};
					phase_d  = PH_HEADER;
					hcount_d = 3'd0;
					bcount_d = 16'd0;
					pend_d   = ST_OK;
				end
			end
			default: begin
				hbytes_d = hb_new;
				hcount_d = hc_new;
				if (hc_new < 3'd4 || hc_new < hlen) begin
					if (item.transfer_last) begin
						has_res = 1'b1;
						res = '{out_byte: 8'd0, out_valid: 1'b0, frame_end: 1'b1,
							frame_status: (hc_new < 3'd4 || (ext && hc_new < 3'd6)) ?
								ST_HDR_CUT : ST_LEN_ERR};
						phase_d  = PH_HEADER;
						hcount_d = 3'd0;
						bcount_d = 16'd0;
						pend_d   = ST_OK;
					end
				end else begin
					// header complete: restart counters, then pick the next phase
					phase_d  = PH_HEADER;
					hcount_d = 3'd0;
					bcount_d = 16'd0;
					pend_d   = ST_OK;
					flen_d   = len;
					if (len == 16'd0 && ok) begin
						has_res = 1'b1;
						res = '{out_byte: 8'd0, out_valid: 1'b0, frame_end: 1'b1,
							frame_status: ST_OK};
					end else if (item.transfer_last) begin
						has_res = 1'b1;
						res = '{out_byte: 8'd0, out_valid: 1'b0, frame_end: 1'b1,
							frame_status: (len == 16'd0) ? ST_NOT_IP : ST_LEN_ERR};
					end else if (ok) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_SKIP;
						pend_d  = ST_NOT_IP;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hcount_q <= 3'd0;
			hbytes_q <= 48'd0;
			flen_q   <= 16'd0;
			bcount_q <= 16'd0;
			pend_q   <= ST_OK;
		end else if (step) begin
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			hbytes_q <= hbytes_d;
			flen_q   <= flen_d;
			bcount_q <= bcount_d;
			pend_q   <= pend_d;
		end
	end

endmodule

// ----- hdl/hip_frame_deframer.sv -----
// Frame deframer top level: input stage, configuration registers, result register
//
// rx channel: one byte of the received transfer per beat, transfer_last set on
// the transfer's final byte. A beat is taken when rx_valid is high and rx_stall low.
// tx channel: at most one result per input beat; out_valid marks a frame byte,
// frame_end closes a frame or an error, frame_status is nonzero on a bad frame.
// The consumer drops any frame whose closing beat has a nonzero status.
// cfg port: cfg_we with cfg_index 0 writes dest_mac, index 1 writes ether_type
// (low 16 bits of cfg_wdata); write only while no bytes are in flight.
// A byte goes into the input register, then through the parse logic into the
// result register, from which its result appears on tx.
// Throughput: one byte per cycle unless tx_stall holds a result; the parse
// state updates on each step. While tx_stall holds a result, rx_stall rises once
// the input register holds a byte, and stays high until the result leaves.
// Reset clears the parser to the header phase, dest_mac to 0 and ether_type
// to 0x0800, and empties both the input and the result registers.
module hip_frame_deframer
	import hfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	output logic                  rx_stall,
	input  hfd_in_t               rx_data,
	output logic                  tx_valid,
	input  logic                  tx_stall,
	output hfd_out_t              tx_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic     rx_valid_s1;
	hfd_in_t  rx_data_s1;
	logic     tx_valid_q;
	hfd_out_t tx_data_q;
	hfd_cfg_t cfg_q;

	logic     out_free;
	logic     step;
	logic     has_res;
	hfd_out_t res;

	assign out_free = !tx_valid_q || !tx_stall;
	assign step     = rx_valid_s1 && out_free;
	assign rx_stall = rx_valid_s1 && !out_free;
	assign tx_valid = tx_valid_q;
	assign tx_data  = tx_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_mac   <= 48'd0;
			cfg_q.ether_type <= 16'h0800;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEST_MAC:   cfg_q.dest_mac   <= cfg_wdata;
				CFG_ETHER_TYPE: cfg_q.ether_type <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			rx_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid)
			rx_data_s1 <= rx_data;
	end

	hfd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (rx_data_s1),
		.cfg     (cfg_q),
		.has_res (has_res),
		.res     (res)
	);

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (out_free) begin
			tx_valid_q <= step && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_res)
			tx_data_q <= res;
	end

endmodule

// ----- hdl/hfd_check.sv -----
// Port checker for the frame deframer, bound to the top level
`include "hip_frame_deframer_macros.svh"

module hfd_check
	import hfd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rx_valid,
	input logic                  rx_stall,
	input hfd_in_t               rx_data,
	input logic                  tx_valid,
	input logic                  tx_stall,
	input hfd_out_t              tx_data,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	`HFD_ASSERT_NEXT(a_tx_hold, tx_valid && tx_stall, tx_valid && $stable(tx_data), "tx beat changed while stalled")
	`HFD_ASSERT_NOW(a_byte_zero, tx_valid && !tx_data.out_valid, tx_data.out_byte == 8'd0, "out_byte nonzero without out_valid")
	`HFD_ASSERT_NOW(a_status_end, tx_valid && !tx_data.frame_end, tx_data.frame_status == ST_OK, "status set on a beat that closes nothing")
	`HFD_ASSERT_NOW(a_beat_kind, tx_valid && !tx_data.out_valid, tx_data.frame_end, "empty result that closes no frame")

endmodule

bind hip_frame_deframer hfd_check u_hfd_check (.*);
